[sv/pfba_pkg.sv]
package pfba_pkg;

  localparam int NUM_WORDS_DEF = 1024;
  localparam int WORD_W = 32;
  localparam int BIT_W = 5;
  localparam int OP_W = 2;
  localparam int FRAME_W = 15;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK = 2'd2;

endpackage

[sv/page_frame_bitmap_allocator.sv]
// First-fit page frame allocator over a free bitmap held in one synchronous RAM of
// NUM_WORDS 32-bit words (bit set = frame free). After reset the block runs a clearing
// pass, with busy high, that marks every frame used. A command is taken when start is
// high and busy is low; its single result comes with a one-cycle done strobe and cannot
// be held off. Free and mark-used do one RAM read and then one write-back. Allocate
// reads one word per cycle, starting at the lowest word that can hold a free frame (a
// running low-water mark), until it finds a free frame or has examined the last word. An
// out-of-range free or mark-used, an unused op and an allocate with no free word left
// answer straight from idle with ok low.
module page_frame_bitmap_allocator
  import pfba_pkg::*;
#(
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    op,
  input  logic [FRAME_W-1:0] frame_number,
  output logic               done,
  output logic               ok,
  output logic [FRAME_W-1:0] alloc_frame
);

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int HW = $clog2(NUM_WORDS + 1);
  localparam int CW = 17;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_UPD = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  logic [WORD_W-1:0] mem [NUM_WORDS];

  logic [1:0]        state;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     chk_addr;
  logic [AW-1:0]     upd_addr;
  logic [BIT_W-1:0]  upd_bit;
  logic              upd_free;
  logic [HW-1:0]     hint;
  logic [WORD_W-1:0] rd_data;

  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;
  logic              accept;
  logic [AW-1:0]     req_addr;
  logic              req_in_range;
  logic [BIT_W-1:0]  low_bit;
  logic [WORD_W-1:0] upd_mask;
  logic              hint_empty;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign req_addr = AW'(frame_number[FRAME_W-1:BIT_W]);
  assign req_in_range = CW'(frame_number[FRAME_W-1:BIT_W]) < CW'(NUM_WORDS);
  assign hint_empty = (hint == HW'(NUM_WORDS));
  assign upd_mask = WORD_W'(1) << upd_bit;

  // lowest set bit of the word under test
  always_comb begin
    low_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (rd_data[i]) begin
        low_bit = BIT_W'(i);
      end
    end
  end

  always_comb begin
    case (state)
      ST_IDLE: rd_addr = (op == OP_ALLOC) ? AW'(hint) : req_addr;
      ST_SCAN: rd_addr = chk_addr + AW'(1);
      default: rd_addr = chk_addr;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = chk_addr;
    wd = '0;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_addr;
      end
      ST_UPD: begin
        we = 1'b1;
        wa = upd_addr;
        wd = upd_free ? (rd_data | upd_mask) : (rd_data & ~upd_mask);
      end
      ST_SCAN: begin
        we = (rd_data != '0);
        wa = chk_addr;
        wd = rd_data & ~(WORD_W'(1) << low_bit);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      hint <= HW'(NUM_WORDS);
      done <= 1'b0;
      ok <= 1'b0;
      alloc_frame <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            upd_addr <= req_addr;
            upd_bit <= frame_number[BIT_W-1:0];
            upd_free <= (op == OP_FREE);
            chk_addr <= AW'(hint);
            if (op == OP_ALLOC) begin
              if (hint_empty) begin
                done <= 1'b1;
                ok <= 1'b0;
                alloc_frame <= '0;
              end else begin
                state <= ST_SCAN;
              end
            end else if ((op == OP_FREE || op == OP_MARK) && req_in_range) begin
              state <= ST_UPD;
            end else begin
              done <= 1'b1;
              ok <= 1'b0;
              alloc_frame <= '0;
            end
          end
        end
        ST_UPD: begin
          if (upd_free && HW'(upd_addr) < hint) begin
            hint <= HW'(upd_addr);
          end
          done <= 1'b1;
          ok <= 1'b1;
          alloc_frame <= '0;
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (rd_data != '0) begin
            done <= 1'b1;
            ok <= 1'b1;
            alloc_frame <= FRAME_W'({chk_addr, low_bit});
            hint <= HW'(chk_addr);
            state <= ST_IDLE;
          end else if (chk_addr == AW'(NUM_WORDS - 1)) begin
            done <= 1'b1;
            ok <= 1'b0;
            alloc_frame <= '0;
            hint <= HW'(NUM_WORDS);
            state <= ST_IDLE;
          end else begin
            chk_addr <= chk_addr + AW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // low-water mark never points past the bitmap
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    hint <= HW'(NUM_WORDS))
    else $error("allocation hint out of range");

  // no beat leaves while the bitmap is being cleared
  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !done)
    else $error("result during clearing pass");

  // an in-range free or mark-used goes to write-back and answers with ok
  a_upd_ok: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_FREE || op == OP_MARK) && req_in_range) |=> ##1 (done && ok))
    else $error("free or mark-used did not complete");

  // a failed beat carries frame zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (alloc_frame == '0))
    else $error("failed result with nonzero frame");

endmodule
